// File: design/boxcar_and_ewma_average_macros.svh
// Assertion macros shared by the boxcar and EWMA average design.
// Included by files that carry concurrent assertions; no other dependencies.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef BOXCAR_AND_EWMA_AVERAGE_MACROS_SVH
`define BOXCAR_AND_EWMA_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, quiet while reset is held.
`define BEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bea assertion failed (same cycle)");

// Next-cycle implication, quiet while reset is held.
`define BEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bea assertion failed (next cycle)");

`else

`define BEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/bea_pkg.sv
// Package for the boxcar and EWMA average: widths, command type, back-end states.
// No dependencies; imported by every module of the design.
`timescale 1ns / 1ps

package bea_pkg;

    localparam int SAMPLE_W              = 32;
    localparam int FILL_W                = 5;
    localparam int DEFAULT_WINDOW_LENGTH = 16;

    // One accepted sample, already run through the EWMA and tagged by the front.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] ewma;
        logic                       filling;  // window not yet full: mean needs a divide
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

// File: design/bea_front.sv
// Front end: accepts samples, updates the EWMA and fill state, tags each transaction.
// Depends on bea_pkg; feeds bea_queue.
`timescale 1ns / 1ps

module bea_front #(
    parameter int WINDOW_LENGTH = bea_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [bea_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_queue_full,
    output logic                                 o_push,
    output bea_pkg::t_cmd                        o_cmd
);
    import bea_pkg::*;

    localparam int WIN_SHIFT = $clog2(WINDOW_LENGTH);
    localparam int WIN_LEN   = 2 ** WIN_SHIFT;
    localparam int CNT_W     = WIN_SHIFT + 1;

    localparam logic [SAMPLE_W:0] BIAS = (SAMPLE_W + 1)'(WIN_LEN - 1);

    logic signed [SAMPLE_W-1:0] r_ewma;
    logic        [CNT_W-1:0]    r_count;
    logic        [CNT_W-1:0]    n_count;

    logic signed [SAMPLE_W:0]   grad;
    logic signed [SAMPLE_W:0]   grad_adj;
    logic signed [SAMPLE_W:0]   step;
    logic signed [SAMPLE_W:0]   ewma_sum;
    logic                       accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    // Divide the gradient by the window length, truncating toward zero.
    always_comb begin
        grad     = {i_sample[SAMPLE_W-1], i_sample} - {r_ewma[SAMPLE_W-1], r_ewma};
        grad_adj = grad[SAMPLE_W] ? grad + $signed(BIAS) : grad;
        step     = grad_adj >>> WIN_SHIFT;
        ewma_sum = {r_ewma[SAMPLE_W-1], r_ewma} + step;
        n_count  = (r_count == CNT_W'(WIN_LEN)) ? r_count : r_count + CNT_W'(1);
    end

    assign o_cmd.sample  = i_sample;
    assign o_cmd.ewma    = ewma_sum[SAMPLE_W-1:0];
    assign o_cmd.filling = (n_count != CNT_W'(WIN_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ewma  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_ewma  <= ewma_sum[SAMPLE_W-1:0];
            r_count <= n_count;
        end
    end

endmodule

// File: design/bea_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on bea_pkg for the command type.
`timescale 1ns / 1ps

module bea_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bea_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output bea_pkg::t_cmd o_cmd
);
    import bea_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: design/bea_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on bea_pkg; used by bea_back for the mean while the window fills.
`timescale 1ns / 1ps

module bea_div #(
    parameter int WINDOW_LENGTH = bea_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic signed [bea_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH)-1:0] i_dividend,
    input  logic        [$clog2(WINDOW_LENGTH):0]                 i_divisor,
    output logic                                                  o_done,
    output logic signed [bea_pkg::SAMPLE_W-1:0]                   o_quotient
);
    import bea_pkg::*;

    localparam int WIN_SHIFT = $clog2(WINDOW_LENGTH);
    localparam int CNT_W     = WIN_SHIFT + 1;
    localparam int SUM_W     = SAMPLE_W + WIN_SHIFT;
    localparam int STEP_W    = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_quo;
    logic              r_neg;

    logic [CNT_W:0]    rem_sh;
    logic              fits;
    logic [CNT_W:0]    rem_sub;
    logic [SUM_W-1:0]  quo_signed;

    always_comb begin
        rem_sh     = {r_rem, r_quo[SUM_W-1]};
        fits       = (rem_sh >= {1'b0, r_div});
        rem_sub    = rem_sh - {1'b0, r_div};
        quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = quo_signed[SAMPLE_W-1:0];

    // Shift the dividend magnitude through r_quo; quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: design/bea_back.sv
// Back end: sample ring, running sum, mean selection and the result register.
// Depends on bea_pkg, bea_div and the assertion macros.
`timescale 1ns / 1ps
`include "boxcar_and_ewma_average_macros.svh"

module bea_back #(
    parameter int WINDOW_LENGTH = bea_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    output logic                                 o_cmd_pop,
    input  bea_pkg::t_cmd                        i_cmd,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_window_mean,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_exp_average,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_oldest_sample,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_middle_sample,
    output logic        [bea_pkg::FILL_W-1:0]    o_fill_count
);
    import bea_pkg::*;

    localparam int WIN_SHIFT = $clog2(WINDOW_LENGTH);
    localparam int WIN_LEN   = 2 ** WIN_SHIFT;
    localparam int POS_W     = WIN_SHIFT;
    localparam int CNT_W     = WIN_SHIFT + 1;
    localparam int SUM_W     = SAMPLE_W + WIN_SHIFT;

    localparam logic [POS_W-1:0] HALF = POS_W'(WIN_LEN / 2);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(WIN_LEN);

    t_back_state              r_state;
    t_back_state              n_state;
    t_cmd                     r_cmd;
    logic [POS_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SAMPLE_W-1:0]      r_old;
    logic [SAMPLE_W-1:0]      r_oldest;
    logic [SAMPLE_W-1:0]      r_mid;
    logic [SAMPLE_W-1:0]      r_mean;

    logic [SAMPLE_W-1:0]      r_ring [WIN_LEN];
    logic [SAMPLE_W-1:0]      r_rd_data;
    logic [POS_W-1:0]         rd_addr;
    logic                     wr_en;

    logic                     r_out_valid;
    logic [SAMPLE_W-1:0]      r_out_mean;
    logic [SAMPLE_W-1:0]      r_out_ewma;
    logic [SAMPLE_W-1:0]      r_out_oldest;
    logic [SAMPLE_W-1:0]      r_out_mid;
    logic [FILL_W-1:0]        r_out_fill;

    logic                     pop;
    logic                     load;
    logic                     div_start;
    logic                     div_done;
    logic [SAMPLE_W-1:0]      div_quo;

    logic [CNT_W-1:0]         n_count;
    logic                     full_now;
    logic                     full_next;
    logic [POS_W-1:0]         mid_idx;
    logic                     mid_written;
    logic signed [SUM_W-1:0]  old_ext;
    logic signed [SUM_W-1:0]  new_ext;
    logic signed [SUM_W-1:0]  sum_shr;
    logic [CNT_W+FILL_W-1:0]  count_ext;

    always_comb begin
        full_now    = (r_count == FULL);
        n_count     = full_now ? r_count : r_count + CNT_W'(1);
        full_next   = (n_count == FULL);
        mid_idx     = r_pos + HALF;
        mid_written = full_now || ({1'b0, mid_idx} < r_count);
        old_ext     = {{WIN_SHIFT{r_old[SAMPLE_W-1]}}, r_old};
        new_ext     = {{WIN_SHIFT{r_cmd.sample[SAMPLE_W-1]}}, r_cmd.sample};
        sum_shr     = r_sum >>> WIN_SHIFT;
        count_ext   = {{FILL_W{1'b0}}, r_count};
    end

    // Sequencer: one read port on the ring, so the three reads are issued in turn in S_RD0, S_RD1 and S_RD2.
    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        load      = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        rd_addr   = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    pop     = 1'b1;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                rd_addr = r_pos;
                n_state = S_RD1;
            end
            S_RD1: begin
                rd_addr = r_pos + POS_W'(1);
                wr_en   = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                rd_addr = r_pos + POS_W'(1) + HALF;
                n_state = S_RD3;
            end
            S_RD3: begin
                if (r_cmd.filling) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_pos] <= r_cmd.sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // Ring entries are written in order from zero, so the fill count tells
    // which ones hold data; unwritten entries read as zero.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_RD1) begin
            r_old <= full_now ? r_rd_data : '0;
        end
        if (r_state == S_RD2) begin
            r_oldest <= full_next ? r_rd_data : '0;
        end
        if (r_state == S_RD3) begin
            r_mid <= mid_written ? r_rd_data : '0;
            if (!r_cmd.filling) begin
                r_mean <= sum_shr[SAMPLE_W-1:0];
            end
        end
        if (r_state == S_DIV && div_done) begin
            r_mean <= div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (r_state == S_RD2) begin
            r_pos   <= r_pos + POS_W'(1);
            r_count <= n_count;
            r_sum   <= r_sum - old_ext + new_ext;
        end
    end

    bea_div #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Result register: holds a finished transaction while the next one is worked on.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_mean   <= r_mean;
            r_out_ewma   <= r_cmd.ewma;
            r_out_oldest <= r_oldest;
            r_out_mid    <= r_mid;
            r_out_fill   <= count_ext[FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_window_mean   = r_out_mean;
    assign o_exp_average   = r_out_ewma;
    assign o_oldest_sample = r_out_oldest;
    assign o_middle_sample = r_out_mid;
    assign o_fill_count    = r_out_fill;

    `BEA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `BEA_ASSERT_IMP(a_front_back_agree, i_clk, i_rst_n, r_state == S_RD3, r_cmd.filling == (r_count != FULL))
    `BEA_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `BEA_ASSERT_NXT(a_div_exits_to_done, i_clk, i_rst_n, r_state == S_DIV, r_state == S_DIV || r_state == S_DONE)

endmodule

// File: design/boxcar_and_ewma_average.sv
// Top level of the boxcar and EWMA average: front end, command queue, back end.
// Depends on bea_pkg, bea_front, bea_queue, bea_back (which holds bea_div).
`timescale 1ns / 1ps

//  channel | valid      | ready       | payload
//  --------+------------+-------------+--------------------------------------------
//  input   | i_in_valid | o_in_ready  | i_sample
//  output  | o_out_valid| i_out_ready | o_window_mean, o_exp_average,
//          |            |             | o_oldest_sample, o_middle_sample, o_fill_count
//
//  Steps: once the window is full a transaction passes through the back end as
//  pop, three reads on the single ring read port, shift, result load. While the
//  window fills, the mean comes from the bit-serial divider over the SUM_W =
//  32 + log2(window) bits of the sum instead of the shift.
//  Reset: synchronous, active low; ring contents need no clearing, the fill count
//  marks which entries hold samples. No clearing pass runs after reset.
//  Stalls: the front end keeps taking samples into a two-entry queue, until it is full,
//  while the back end works and while a finished result waits in the output register.
module boxcar_and_ewma_average #(
    parameter int WINDOW_LENGTH = bea_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [bea_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_window_mean,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_exp_average,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_oldest_sample,
    output logic signed [bea_pkg::SAMPLE_W-1:0]  o_middle_sample,
    output logic        [bea_pkg::FILL_W-1:0]    o_fill_count
);
    import bea_pkg::*;

    // Front to queue
    logic push;
    t_cmd push_cmd;
    logic queue_full;

    // Queue to back
    logic queue_valid;
    logic queue_pop;
    t_cmd head_cmd;

    // Advance the EWMA and classify each sample as it arrives.
    bea_front #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Hold tagged transactions so either side can stall on its own.
    bea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_cmd   (head_cmd)
    );

    // Update the ring and sum, pick shift or divide for the mean, drive results.
    bea_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (queue_valid),
        .o_cmd_pop       (queue_pop),
        .i_cmd           (head_cmd),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_window_mean   (o_window_mean),
        .o_exp_average   (o_exp_average),
        .o_oldest_sample (o_oldest_sample),
        .o_middle_sample (o_middle_sample),
        .o_fill_count    (o_fill_count)
    );

endmodule

// File: tb/boxcar_and_ewma_average_checker.sv
// Checker for the boxcar and EWMA average: predicts each result from accepted samples.
// Compares every output transaction field by field; depends on bea_pkg.
`timescale 1ns / 1ps

module boxcar_and_ewma_average_checker #(
    parameter int WINDOW_LENGTH = bea_pkg::DEFAULT_WINDOW_LENGTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [bea_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bea_pkg::SAMPLE_W-1:0] i_window_mean,
    input  logic signed [bea_pkg::SAMPLE_W-1:0] i_exp_average,
    input  logic signed [bea_pkg::SAMPLE_W-1:0] i_oldest_sample,
    input  logic signed [bea_pkg::SAMPLE_W-1:0] i_middle_sample,
    input  logic        [bea_pkg::FILL_W-1:0]   i_fill_count,
    output int                                  o_mismatch_count,
    output int                                  o_pending
);
    import bea_pkg::*;

    // Window length rounded up to a power of two.
    localparam int RING_SHIFT = $clog2(WINDOW_LENGTH);
    localparam int RING_LEN   = 1 << RING_SHIFT;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] ewma;
        logic signed [SAMPLE_W-1:0] oldest;
        logic signed [SAMPLE_W-1:0] middle;
        logic        [FILL_W-1:0]   fill;
    } t_window_stats;

    logic signed [SAMPLE_W-1:0] ring_copy [RING_LEN];
    longint                     window_sum;
    int                         wr_pos;
    int                         fill_level;
    logic signed [SAMPLE_W-1:0] ewma_track;

    t_window_stats stats_q [$];
    int            mismatches = 0;
    int            result_index = 0;

    assign o_mismatch_count = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf(
                "result %0d %s: got %0d (0x%08h), expected %0d (0x%08h)",
                result_index, field, $signed(got), got, $signed(want), want));
    endtask

    // Fold one sample into the window and return the stats it produces.
    function automatic t_window_stats advance_window(input logic signed [SAMPLE_W-1:0] sample);
        t_window_stats stats;
        longint        step;
        longint        acc;
        longint        mean_val;
        int            mid;

        // EWMA moves by the difference over the length, truncated toward zero.
        step       = (longint'(sample) - longint'(ewma_track)) / longint'(RING_LEN);
        acc        = longint'(ewma_track) + step;
        ewma_track = acc[SAMPLE_W-1:0];

        window_sum          = window_sum - longint'(ring_copy[wr_pos]) + longint'(sample);
        ring_copy[wr_pos]   = sample;
        wr_pos              = (wr_pos + 1) & (RING_LEN - 1);
        if (fill_level < RING_LEN)
            fill_level++;

        // Divide while filling, arithmetic shift once full.
        if (fill_level < RING_LEN)
            mean_val = window_sum / longint'(fill_level);
        else
            mean_val = window_sum >>> RING_SHIFT;

        mid          = (wr_pos + RING_LEN / 2) & (RING_LEN - 1);
        stats.mean   = mean_val[SAMPLE_W-1:0];
        stats.ewma   = ewma_track;
        stats.oldest = ring_copy[wr_pos];
        stats.middle = ring_copy[mid];
        stats.fill   = fill_level[FILL_W-1:0];
        return stats;
    endfunction

    always @(posedge i_clk) begin
        t_window_stats want;
        if (!i_rst_n) begin
            for (int k = 0; k < RING_LEN; k++)
                ring_copy[k] = '0;
            window_sum = 0;
            wr_pos     = 0;
            fill_level = 0;
            ewma_track = '0;
            stats_q.delete();
            o_pending <= 0;
        end else begin
            // Check the output transaction against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (stats_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no sample pending, mean %0d",
                                              result_index, i_window_mean));
                end else begin
                    want = stats_q.pop_front();
                    compare_field("window_mean", i_window_mean, want.mean);
                    compare_field("exp_average", i_exp_average, want.ewma);
                    compare_field("oldest_sample", i_oldest_sample, want.oldest);
                    compare_field("middle_sample", i_middle_sample, want.middle);
                    compare_field("fill_count", 32'(i_fill_count), 32'(want.fill));
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready)
                stats_q.push_back(advance_window(i_sample));
            o_pending <= stats_q.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for the boxcar and EWMA average: clock, reset, stimulus and verdict.
// Depends on bea_pkg, boxcar_and_ewma_average and boxcar_and_ewma_average_checker.
`timescale 1ns / 1ps

module tb_top;
    import bea_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS    = 450;
    localparam int HOLD_OFF_AT     = 120;  // random transaction that triggers the long hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_AT        = 300;  // random transaction after which the sender drains
    localparam int SETTLE_CYCLES   = 120;  // covers the slowest back-end pass with margin
    // Allow far more than the slowest correct run takes.
    localparam int TIMEOUT_NS      = 800_000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_out_ready = 1'b0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_window_mean;
    logic signed [SAMPLE_W-1:0] o_exp_average;
    logic signed [SAMPLE_W-1:0] o_oldest_sample;
    logic signed [SAMPLE_W-1:0] o_middle_sample;
    logic        [FILL_W-1:0]   o_fill_count;

    int mismatch_count;
    int pending_results;
    bit hold_off_req = 1'b0;

    boxcar_and_ewma_average DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_window_mean   (o_window_mean),
        .o_exp_average   (o_exp_average),
        .o_oldest_sample (o_oldest_sample),
        .o_middle_sample (o_middle_sample),
        .o_fill_count    (o_fill_count)
    );

    boxcar_and_ewma_average_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_window_mean    (o_window_mean),
        .i_exp_average    (o_exp_average),
        .i_oldest_sample  (o_oldest_sample),
        .i_middle_sample  (o_middle_sample),
        .i_fill_count     (o_fill_count),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    // 2 ns clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL boxcar_and_ewma_average");
        $finish;
    end

    // Offer one sample and hold it until the transaction is accepted.
    // Returns at the accepting edge, so the next call can drive straight away.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        i_in_valid <= 1'b1;
        i_sample   <= value;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has been returned.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
    endtask

    // Receiver: cycle through its own stall patterns, with one long hold-off
    // on request so the input queue fills and the block stalls its input.
    initial begin
        int unsigned stall_tick;
        bit          hold_off_done;
        stall_tick    = 0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                stall_tick++;
                case ((stall_tick / 80) % 4)
                    0: i_out_ready <= 1'b1;                          // no stalls
                    1: i_out_ready <= 1'($urandom_range(0, 1));      // coin flip
                    2: i_out_ready <= (stall_tick % 5 == 0);         // mostly stalled
                    default: i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Sender: reset, directed samples, then random bursts.
    initial begin
        int                         sent;
        int                         burst_len;
        int                         kind;
        int                         gap;
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] run_value;

        // Hold reset, then release.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: negative sums that truncate toward zero while filling,
        // both extremes, then a full window of the minimum (most negative sum)
        // and the maximum pushing the oldest entries out.
        send_sample(-32'sd1);
        send_sample(32'sd0);
        send_sample(-32'sd4);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        repeat (16) send_sample(SAMPLE_MIN);
        repeat (4) send_sample(SAMPLE_MAX);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind      = $urandom_range(0, 6);
            burst_len = $urandom_range(1, 24);
            // Constant runs span at least a window so the sum reaches its extremes.
            if (kind == 5) begin
                burst_len = $urandom_range(16, 20);
                case ($urandom_range(0, 3))
                    0: run_value = SAMPLE_MAX;
                    1: run_value = SAMPLE_MIN;
                    2: run_value = -32'sd1;
                    default: run_value = $urandom;
                endcase
            end
            for (int k = 0; k < burst_len; k++) begin
                case (kind)
                    0, 1: value = $urandom;
                    2: value = int'($urandom_range(0, 80)) - 40;
                    3: value = $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 15)
                                                    : SAMPLE_MIN + $urandom_range(0, 15);
                    4: begin
                        // Single bit set or single bit clear.
                        value = 32'sd1 <<< $urandom_range(0, 31);
                        if ($urandom_range(0, 1))
                            value = ~value;
                    end
                    5: value = run_value;
                    default: value = $urandom_range(0, 1) ? $urandom
                                                          : int'($urandom_range(0, 2000)) - 1000;
                endcase
                send_sample(value);
                sent++;
                if (sent == HOLD_OFF_AT)
                    hold_off_req <= 1'b1;
                if (sent == DRAIN_AT)
                    drain_results();
            end
            // Back-to-back bursts about a quarter of the time.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // Wait out every result, then watch for strays.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("PASS boxcar_and_ewma_average");
        end else begin
            $display("FAIL boxcar_and_ewma_average");
        end
        $finish;
    end

endmodule
